### design/mppb_pkg.sv
// Shared types and constants for the prime power and binomial block.
// Used by mppb_mulmod and mod_prime_power_and_binomial; depends on nothing.
package mppb_pkg;

  localparam int RES_W  = 30;
  localparam int BASE_W = 32;
  localparam int EXP_W  = 31;
  localparam int NV_W   = 11;
  localparam int N_MAX_DEF = 1024;

  localparam logic [RES_W-1:0] MOD = 30'd1000000007;
  localparam logic [EXP_W-1:0] FERMAT_EXP = 31'd1000000005;
  localparam logic [RES_W-1:0] ONE = 30'd1;

  localparam logic OP_POWER = 1'b0;
  localparam logic OP_BINOM = 1'b1;

  typedef struct packed {
    logic             start;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RES_W-1:0] prod;
  } mul_rsp_t;

endpackage

### design/mod_prime_power_and_binomial.sv
// Top level: sequencer for modular power and binomial coefficient mod 1000000007.
// Depends on mppb_pkg and on the bit-serial multiplier mppb_mulmod.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  operation, base, exponent, n_value, r_value
//   out      out_valid / out_ready result, error
//
// Every multiplication runs on one shared bit-serial multiplier.
// Power reduces the base, then squares once per exponent bit and multiplies once more per set bit.
// Binomial runs n product steps for the factorials, one product to combine the two
// factorials, 45 for the Fermat inverse and one final product.
// Reset clears the sequencer and the output valid; one item is in work at a time.
// A new beat is accepted while the previous result still waits on out_ready.
module mod_prime_power_and_binomial #(
  parameter int N_MAX = mppb_pkg::N_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [mppb_pkg::BASE_W-1:0]  base,
  input  logic [mppb_pkg::EXP_W-1:0]   exponent,
  input  logic [mppb_pkg::NV_W-1:0]    n_value,
  input  logic [mppb_pkg::NV_W-1:0]    r_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mppb_pkg::RES_W-1:0]   result,
  output logic                         error
);

  localparam int W  = mppb_pkg::RES_W;
  localparam int BW = mppb_pkg::BASE_W;
  localparam int EW = mppb_pkg::EXP_W;
  localparam int NW = mppb_pkg::NV_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_PSTEP, S_PMUL_A, S_PMUL_B,
    S_FACT, S_FMUL, S_CMUL, S_LAST, S_DONE
  } state_t;

  state_t             state;
  mppb_pkg::mul_req_t mreq;
  mppb_pkg::mul_rsp_t mrsp;

  logic [BW-1:0] a_reg;
  logic [W-1:0]  acc;
  logic [W-1:0]  pb;
  logic [EW-1:0] e_reg;
  logic          binom;
  logic [W-1:0]  f;
  logic [W-1:0]  fr;
  logic [W-1:0]  fnr;
  logic [NW-1:0] i;
  logic [NW-1:0] n_reg;
  logic [NW-1:0] r_reg;
  logic [NW-1:0] nr_reg;
  logic [W-1:0]  res_reg;
  logic          err_reg;
  logic          accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  mppb_mulmod u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      mreq.start <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          mreq.start <= 1'b0;
          if (accept) begin
            if (operation == mppb_pkg::OP_POWER) begin
              a_reg <= base;
              e_reg <= exponent;
              acc   <= mppb_pkg::ONE;
              binom <= 1'b0;
              state <= S_RED;
            end else if (32'(n_value) > N_MAX || r_value > n_value) begin
              res_reg <= '0;
              err_reg <= 1'b1;
              state   <= S_DONE;
            end else if (r_value == '0) begin
              res_reg <= mppb_pkg::ONE;
              err_reg <= 1'b0;
              state   <= S_DONE;
            end else begin
              n_reg  <= n_value;
              r_reg  <= r_value;
              nr_reg <= n_value - r_value;
              f      <= mppb_pkg::ONE;
              fnr    <= mppb_pkg::ONE;
              fr     <= mppb_pkg::ONE;
              i      <= NW'(1);
              binom  <= 1'b1;
              state  <= S_FACT;
            end
          end
        end
        S_RED: begin
          mreq.start <= 1'b0;
          if (a_reg >= BW'(mppb_pkg::MOD)) begin
            a_reg <= a_reg - BW'(mppb_pkg::MOD);
          end else begin
            pb    <= W'(a_reg);
            state <= S_PSTEP;
          end
        end
        S_PSTEP: begin
          if (e_reg == '0) begin
            if (binom) begin
              mreq.start <= 1'b1;
              mreq.a     <= f;
              mreq.b     <= acc;
              state      <= S_LAST;
            end else begin
              mreq.start <= 1'b0;
              res_reg    <= acc;
              err_reg    <= 1'b0;
              state      <= S_DONE;
            end
          end else if (e_reg[0]) begin
            mreq.start <= 1'b1;
            mreq.a     <= acc;
            mreq.b     <= pb;
            state      <= S_PMUL_A;
          end else begin
            mreq.start <= 1'b1;
            mreq.a     <= pb;
            mreq.b     <= pb;
            state      <= S_PMUL_B;
          end
        end
        S_PMUL_A: begin
          if (mrsp.done) begin
            acc        <= mrsp.prod;
            mreq.start <= 1'b1;
            mreq.a     <= pb;
            mreq.b     <= pb;
            state      <= S_PMUL_B;
          end else begin
            mreq.start <= 1'b0;
          end
        end
        S_PMUL_B: begin
          mreq.start <= 1'b0;
          if (mrsp.done) begin
            pb    <= mrsp.prod;
            e_reg <= e_reg >> 1;
            state <= S_PSTEP;
          end
        end
        S_FACT: begin
          mreq.start <= 1'b1;
          mreq.a     <= f;
          mreq.b     <= W'(i);
          state      <= S_FMUL;
        end
        S_FMUL: begin
          mreq.start <= 1'b0;
          if (mrsp.done) begin
            f <= mrsp.prod;
            if (i == r_reg) begin
              fr <= mrsp.prod;
            end
            if (i == nr_reg) begin
              fnr <= mrsp.prod;
            end
            if (i == n_reg) begin
              state <= S_CMUL;
            end else begin
              i     <= i + 1'b1;
              state <= S_FACT;
            end
          end
        end
        S_CMUL: begin
          if (!mrsp.busy && !mreq.start && !mrsp.done) begin
            mreq.start <= 1'b1;
            mreq.a     <= fr;
            mreq.b     <= fnr;
            state      <= S_PMUL_B;
            acc        <= mppb_pkg::ONE;
            e_reg      <= mppb_pkg::FERMAT_EXP << 1;
          end else begin
            mreq.start <= 1'b0;
          end
        end
        S_LAST: begin
          mreq.start <= 1'b0;
          if (mrsp.done) begin
            res_reg <= mrsp.prod;
            err_reg <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          mreq.start <= 1'b0;
          if (!out_valid || out_ready) begin
            result    <= res_reg;
            error     <= err_reg;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          mreq.start <= 1'b0;
          state      <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result < mppb_pkg::MOD))
    else $error("result beat not reduced modulo the prime");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (result == '0))
    else $error("error beat carries a nonzero result");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second beat accepted while an item is in work");
`endif

endmodule

### design/mppb_mulmod.sv
// Bit-serial modular multiplier: one bit of the second operand per cycle.
// Depends on mppb_pkg for the modulus, widths and request/response structs.
module mppb_mulmod (
  input  logic               clk,
  input  logic               rst,
  input  mppb_pkg::mul_req_t req,
  output mppb_pkg::mul_rsp_t rsp
);

  localparam int W = mppb_pkg::RES_W;
  localparam int CW = $clog2(W);
  localparam logic [W+1:0] MOD_X1 = {2'b00, mppb_pkg::MOD};
  localparam logic [W+1:0] MOD_X2 = {1'b0, mppb_pkg::MOD, 1'b0};

  logic [W-1:0]  acc;
  logic [W-1:0]  acc_next;
  logic [W-1:0]  a_op;
  logic [W-1:0]  b_sh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W+1:0]  sum;

  always_comb begin
    sum = {1'b0, acc, 1'b0} + {2'b00, (b_sh[W-1] ? a_op : {W{1'b0}})};
    if (sum >= MOD_X2) begin
      acc_next = W'(sum - MOD_X2);
    end else if (sum >= MOD_X1) begin
      acc_next = W'(sum - MOD_X1);
    end else begin
      acc_next = W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == CW'(W - 1));
      if (req.start) begin
        a_op <= req.a;
        b_sh <= req.b;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc  <= acc_next;
        b_sh <= {b_sh[W-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = acc;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done held longer than one cycle");
  a_prod_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (acc < mppb_pkg::MOD))
    else $error("multiplier product not reduced");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while still busy");
`endif

endmodule
